// File: hdl/ctcgd_pkg.sv
`timescale 1ns / 1ps

package ctcgd_pkg;

    localparam int PROB_W      = 16;
    localparam int CLASS_W     = 13;
    localparam int KEY_W       = 14;
    localparam int SUM_W       = 26;
    localparam int CNT_W       = 11;
    localparam int MAX_CLASSES = 8192;
    localparam int MAX_STEPS   = 1024;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam logic [ADDR_W-1:0] ADDR_KEY_COUNT = 3'd0;
    localparam logic [KEY_W-1:0]  KEY_COUNT_RESET = 14'd8192;

    localparam logic KIND_TOKEN = 1'b0;
    localparam logic KIND_MEAN  = 1'b1;

    // one record per step end or sequence end that produces results
    typedef struct packed {
        logic               tok_valid;
        logic [CLASS_W-1:0] tok_index;
        logic [PROB_W-1:0]  tok_prob;
        logic [CNT_W-1:0]   tok_total;
        logic               mean_valid;
        logic [SUM_W-1:0]   mean_dividend;
        logic [CNT_W-1:0]   mean_count;
    } t_entry;

endpackage

// File: hdl/ctcgd_front.sv
`timescale 1ns / 1ps

module ctcgd_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic [ctcgd_pkg::PROB_W-1:0]     i_class_prob,
    input  logic                             i_step_end,
    input  logic                             i_sequence_end,
    input  logic [ctcgd_pkg::KEY_W-1:0]      i_key_count,
    input  logic                             i_fifo_full,
    output logic                             o_fifo_wr,
    output ctcgd_pkg::t_entry                o_entry
);

    localparam logic [ctcgd_pkg::CLASS_W-1:0] POS_LAST =
        ctcgd_pkg::CLASS_W'(ctcgd_pkg::MAX_CLASSES - 1);
    localparam logic [ctcgd_pkg::CNT_W-1:0] CNT_MAX =
        ctcgd_pkg::CNT_W'(ctcgd_pkg::MAX_STEPS);

    logic [ctcgd_pkg::CLASS_W-1:0] r_pos, n_pos;
    logic [ctcgd_pkg::PROB_W-1:0]  r_best_prob, n_best_prob;
    logic [ctcgd_pkg::CLASS_W-1:0] r_best_class, n_best_class;
    logic [ctcgd_pkg::CLASS_W-1:0] r_prev, n_prev;
    logic                          r_prev_valid, n_prev_valid;
    logic [ctcgd_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [ctcgd_pkg::CNT_W-1:0]   r_cnt, n_cnt;

    logic                          take;
    logic                          cand_new;
    logic                          ends;
    logic                          emit;
    logic [ctcgd_pkg::PROB_W-1:0]  w_prob;
    logic [ctcgd_pkg::CLASS_W-1:0] w_class;
    logic [ctcgd_pkg::SUM_W-1:0]   sum_upd;
    logic [ctcgd_pkg::CNT_W-1:0]   cnt_upd;

    always_comb begin
        take     = i_push && !i_fifo_full;
        cand_new = (r_pos == '0) || (i_class_prob > r_best_prob);
        w_prob   = cand_new ? i_class_prob : r_best_prob;
        w_class  = cand_new ? r_pos : r_best_class;
        ends     = i_step_end || i_sequence_end;
        emit     = ends && (w_class != '0) && (!r_prev_valid || (w_class != r_prev))
                   && ({1'b0, w_class} < i_key_count);

        sum_upd = r_sum;
        cnt_upd = r_cnt;
        if (emit && (r_cnt != CNT_MAX)) begin
            sum_upd = r_sum + {{(ctcgd_pkg::SUM_W-ctcgd_pkg::PROB_W){1'b0}}, w_prob};
            cnt_upd = r_cnt + 1'b1;
        end

        o_entry.tok_valid     = emit;
        o_entry.tok_index     = w_class;
        o_entry.tok_prob      = w_prob;
        o_entry.tok_total     = cnt_upd;
        o_entry.mean_valid    = i_sequence_end;
        o_entry.mean_dividend = sum_upd
            + {{(ctcgd_pkg::SUM_W-ctcgd_pkg::CNT_W){1'b0}}, (cnt_upd >> 1)};
        o_entry.mean_count    = cnt_upd;
        o_fifo_wr             = take && (emit || i_sequence_end);

        n_pos        = r_pos;
        n_best_prob  = r_best_prob;
        n_best_class = r_best_class;
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        n_sum        = r_sum;
        n_cnt        = r_cnt;
        if (take) begin
            n_sum = sum_upd;
            n_cnt = cnt_upd;
            if (ends) begin
                n_pos        = '0;
                n_best_prob  = '0;
                n_best_class = '0;
                n_prev       = w_class;
                n_prev_valid = 1'b1;
            end else begin
                n_best_prob  = w_prob;
                n_best_class = w_class;
                if (r_pos != POS_LAST) begin
                    n_pos = r_pos + 1'b1;
                end
            end
            if (i_sequence_end) begin
                n_prev       = '0;
                n_prev_valid = 1'b0;
                n_sum        = '0;
                n_cnt        = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_best_prob  <= '0;
            r_best_class <= '0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_sum        <= '0;
            r_cnt        <= '0;
        end else begin
            r_pos        <= n_pos;
            r_best_prob  <= n_best_prob;
            r_best_class <= n_best_class;
            r_prev       <= n_prev;
            r_prev_valid <= n_prev_valid;
            r_sum        <= n_sum;
            r_cnt        <= n_cnt;
        end
    end

endmodule

// File: hdl/ctcgd_fifo.sv
`timescale 1ns / 1ps

module ctcgd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  ctcgd_pkg::t_entry i_data,
    output logic              o_full,
    input  logic              i_rd,
    output logic              o_empty,
    output ctcgd_pkg::t_entry o_data
);

    localparam logic [ctcgd_pkg::FIFO_CW-1:0] DEPTH_CNT =
        ctcgd_pkg::FIFO_CW'(ctcgd_pkg::FIFO_DEPTH);

    ctcgd_pkg::t_entry r_mem [ctcgd_pkg::FIFO_DEPTH];
    logic [ctcgd_pkg::FIFO_AW-1:0] r_wr_ptr;
    logic [ctcgd_pkg::FIFO_AW-1:0] r_rd_ptr;
    logic [ctcgd_pkg::FIFO_CW-1:0] r_count;

    logic do_wr;
    logic do_rd;

    assign o_full  = (r_count == DEPTH_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hdl/ctcgd_back.sv
`timescale 1ns / 1ps

module ctcgd_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fifo_empty,
    input  ctcgd_pkg::t_entry                i_entry,
    output logic                             o_fifo_rd,
    input  logic                             i_pop,
    output logic                             o_empty,
    output logic                             o_result_kind,
    output logic [ctcgd_pkg::CLASS_W-1:0]    o_token_index,
    output logic [ctcgd_pkg::PROB_W-1:0]     o_token_prob,
    output logic [ctcgd_pkg::PROB_W-1:0]     o_mean_score,
    output logic [ctcgd_pkg::CNT_W-1:0]      o_token_total,
    output logic                             o_run_last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_TOKEN = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_MEAN  = 2'd3;

    localparam int STEP_W = $clog2(ctcgd_pkg::SUM_W + 1);
    localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(ctcgd_pkg::SUM_W);

    logic [1:0]                    r_state, n_state;
    ctcgd_pkg::t_entry             r_cur;
    logic [ctcgd_pkg::SUM_W-1:0]   r_quo;
    logic [ctcgd_pkg::CNT_W-1:0]   r_rem;
    logic [STEP_W-1:0]             r_step;
    logic                          r_out_valid;

    logic                          slot_free;
    logic                          load_token;
    logic                          load_mean;
    logic [ctcgd_pkg::CNT_W:0]     shifted;
    logic [ctcgd_pkg::CNT_W:0]     diff;
    logic                          q_bit;

    always_comb begin
        slot_free  = !r_out_valid || i_pop;
        o_fifo_rd  = (r_state == ST_IDLE) && !i_fifo_empty;
        load_token = (r_state == ST_TOKEN) && slot_free;
        load_mean  = (r_state == ST_MEAN) && slot_free;

        // restoring division, one quotient bit per cycle
        shifted = {r_rem, r_quo[ctcgd_pkg::SUM_W-1]};
        diff    = shifted - {1'b0, r_cur.mean_count};
        q_bit   = (shifted >= {1'b0, r_cur.mean_count});

        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_fifo_empty) begin
                    n_state = i_entry.tok_valid ? ST_TOKEN : ST_DIV;
                end
            end
            ST_TOKEN: begin
                if (slot_free) begin
                    n_state = r_cur.mean_valid ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV: begin
                if (r_step == STEP_W'(1)) begin
                    n_state = ST_MEAN;
                end
            end
            ST_MEAN: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_fifo_rd) begin
            r_cur <= i_entry;
            r_quo <= i_entry.mean_dividend;
            r_rem <= '0;
        end else if (r_state == ST_DIV) begin
            r_quo <= {r_quo[ctcgd_pkg::SUM_W-2:0], q_bit};
            r_rem <= q_bit ? diff[ctcgd_pkg::CNT_W-1:0] : shifted[ctcgd_pkg::CNT_W-1:0];
        end
        if (load_token) begin
            o_result_kind <= ctcgd_pkg::KIND_TOKEN;
            o_token_index <= r_cur.tok_index;
            o_token_prob  <= r_cur.tok_prob;
            o_mean_score  <= '0;
            o_token_total <= r_cur.tok_total;
            o_run_last    <= !r_cur.mean_valid;
        end else if (load_mean) begin
            o_result_kind <= ctcgd_pkg::KIND_MEAN;
            o_token_index <= '0;
            o_token_prob  <= '0;
            o_mean_score  <= (r_cur.mean_count == '0) ? '0 : r_quo[ctcgd_pkg::PROB_W-1:0];
            o_token_total <= r_cur.mean_count;
            o_run_last    <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_fifo_rd) begin
                r_step <= DIV_STEPS;
            end else if (r_state == ST_DIV) begin
                r_step <= r_step - 1'b1;
            end
            if (load_token || load_mean) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty = !r_out_valid;

endmodule

// File: hdl/ctc_greedy_decoder.sv
`timescale 1ns / 1ps

// greedy best-path decoder for ctc output: class probabilities of each time step stream in one
// per transfer, and the block emits every new non-blank winning class below key_count plus a
// rounded mean score at sequence end. the front stage takes one class per cycle whenever its
// four-entry record queue has room; the back stage takes one record at a time, each token through
// its token state, and the sequence mean through the 26-step restoring divider.
// no clearing pass is needed after reset.

module ctc_greedy_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [ctcgd_pkg::PROB_W-1:0]     i_class_prob,
    input  logic                             i_step_end,
    input  logic                             i_sequence_end,
    output logic                             empty,
    input  logic                             pop,
    output logic                             o_result_kind,
    output logic [ctcgd_pkg::CLASS_W-1:0]    o_token_index,
    output logic [ctcgd_pkg::PROB_W-1:0]     o_token_prob,
    output logic [ctcgd_pkg::PROB_W-1:0]     o_mean_score,
    output logic [ctcgd_pkg::CNT_W-1:0]      o_token_total,
    output logic                             o_run_last,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ctcgd_pkg::ADDR_W-1:0]     paddr,
    input  logic [ctcgd_pkg::DATA_W-1:0]     pwdata,
    output logic [ctcgd_pkg::DATA_W-1:0]     prdata,
    output logic                             pready
);

    localparam logic [ctcgd_pkg::ADDR_W-3:0] WORD_KEY_COUNT =
        ctcgd_pkg::ADDR_KEY_COUNT[ctcgd_pkg::ADDR_W-1:2];

    logic [ctcgd_pkg::KEY_W-1:0] r_key_count;
    logic                        sel_key_count;
    logic                        fifo_wr;
    logic                        fifo_rd;
    logic                        fifo_full;
    logic                        fifo_empty;
    ctcgd_pkg::t_entry           wr_entry;
    ctcgd_pkg::t_entry           rd_entry;

    assign pready        = 1'b1;
    assign full          = fifo_full;
    assign sel_key_count = (paddr[ctcgd_pkg::ADDR_W-1:2] == WORD_KEY_COUNT);
    assign prdata = sel_key_count
        ? {{(ctcgd_pkg::DATA_W-ctcgd_pkg::KEY_W){1'b0}}, r_key_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= ctcgd_pkg::KEY_COUNT_RESET;
        end else if (psel && penable && pwrite && pready && sel_key_count) begin
            r_key_count <= pwdata[ctcgd_pkg::KEY_W-1:0];
        end
    end

    ctcgd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_class_prob   (i_class_prob),
        .i_step_end     (i_step_end),
        .i_sequence_end (i_sequence_end),
        .i_key_count    (r_key_count),
        .i_fifo_full    (fifo_full),
        .o_fifo_wr      (fifo_wr),
        .o_entry        (wr_entry)
    );

    ctcgd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fifo_wr),
        .i_data  (wr_entry),
        .o_full  (fifo_full),
        .i_rd    (fifo_rd),
        .o_empty (fifo_empty),
        .o_data  (rd_entry)
    );

    ctcgd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fifo_empty  (fifo_empty),
        .i_entry       (rd_entry),
        .o_fifo_rd     (fifo_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_result_kind (o_result_kind),
        .o_token_index (o_token_index),
        .o_token_prob  (o_token_prob),
        .o_mean_score  (o_mean_score),
        .o_token_total (o_token_total),
        .o_run_last    (o_run_last)
    );

endmodule

// File: bench/ctc_greedy_decoder_tb.sv
`timescale 1ns / 1ps

module ctc_greedy_decoder_tb;

    localparam int PREDICT        = -1;
    localparam int NO_CFG         = -1;
    localparam int RANDOM_KEY     = -1;
    localparam int N_PHASES       = 8;
    localparam int PHASE_ITEMS    = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic                          kind;
        logic [ctcgd_pkg::CLASS_W-1:0] index;
        logic [ctcgd_pkg::PROB_W-1:0]  prob;
        logic [ctcgd_pkg::PROB_W-1:0]  mean;
        logic [ctcgd_pkg::CNT_W-1:0]   total;
        logic                          last;
    } t_dec_result;

    typedef struct {
        int                           key_before;
        logic [ctcgd_pkg::PROB_W-1:0] prob;
        logic                         se;
        logic                         qe;
        int                           n_typed;
        t_dec_result                  res0;
        t_dec_result                  res1;
    } t_stim_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            push = 1'b0;
    logic                            full;
    logic [ctcgd_pkg::PROB_W-1:0]    i_class_prob = '0;
    logic                            i_step_end = 1'b0;
    logic                            i_sequence_end = 1'b0;
    logic                            empty;
    logic                            pop = 1'b0;
    logic                            o_result_kind;
    logic [ctcgd_pkg::CLASS_W-1:0]   o_token_index;
    logic [ctcgd_pkg::PROB_W-1:0]    o_token_prob;
    logic [ctcgd_pkg::PROB_W-1:0]    o_mean_score;
    logic [ctcgd_pkg::CNT_W-1:0]     o_token_total;
    logic                            o_run_last;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [ctcgd_pkg::ADDR_W-1:0]    paddr = '0;
    logic [ctcgd_pkg::DATA_W-1:0]    pwdata = '0;
    logic [ctcgd_pkg::DATA_W-1:0]    prdata;
    logic                            pready;

    ctc_greedy_decoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_class_prob   (i_class_prob),
        .i_step_end     (i_step_end),
        .i_sequence_end (i_sequence_end),
        .empty          (empty),
        .pop            (pop),
        .o_result_kind  (o_result_kind),
        .o_token_index  (o_token_index),
        .o_token_prob   (o_token_prob),
        .o_mean_score   (o_mean_score),
        .o_token_total  (o_token_total),
        .o_run_last     (o_run_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // decoder state mirror
    int                              scan_pos;
    logic [ctcgd_pkg::PROB_W-1:0]    scan_best_prob;
    int                              scan_best_class;
    int                              last_winner;
    bit                              last_winner_valid;
    int                              token_sum;
    int                              token_count;
    logic [ctcgd_pkg::KEY_W-1:0]     key_limit;

    t_dec_result        pending_results [$];
    t_dec_result        step_results [2];
    int                 step_result_count;
    t_dec_result        typed_res [2];
    int                 typed_n = PREDICT;
    t_stim_row          stim_rows [$];

    int                 error_count = 0;
    int                 items_sent = 0;
    int                 stall_cycles = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    bit                 hold_req = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic t_dec_result token_result(int idx, int prob, int total, bit last);
        t_dec_result r;
        r.kind  = ctcgd_pkg::KIND_TOKEN;
        r.index = ctcgd_pkg::CLASS_W'(idx);
        r.prob  = ctcgd_pkg::PROB_W'(prob);
        r.mean  = '0;
        r.total = ctcgd_pkg::CNT_W'(total);
        r.last  = last;
        return r;
    endfunction

    function automatic t_dec_result mean_result(int mean, int total, bit last);
        t_dec_result r;
        r.kind  = ctcgd_pkg::KIND_MEAN;
        r.index = '0;
        r.prob  = '0;
        r.mean  = ctcgd_pkg::PROB_W'(mean);
        r.total = ctcgd_pkg::CNT_W'(total);
        r.last  = last;
        return r;
    endfunction

    function automatic void clear_sequence();
        scan_pos          = 0;
        scan_best_prob    = '0;
        scan_best_class   = 0;
        last_winner       = 0;
        last_winner_valid = 1'b0;
        token_sum         = 0;
        token_count       = 0;
    endfunction

    function automatic void decode_item(logic [ctcgd_pkg::PROB_W-1:0] p, logic se, logic qe);
        int                           winner;
        logic [ctcgd_pkg::PROB_W-1:0] winner_prob;
        int                           mean;
        step_result_count = 0;
        if (scan_pos == 0 || p > scan_best_prob) begin
            scan_best_prob  = p;
            scan_best_class = scan_pos;
        end
        if (scan_pos < ctcgd_pkg::MAX_CLASSES - 1)
            scan_pos++;
        if (se || qe) begin
            winner      = scan_best_class;
            winner_prob = scan_best_prob;
            if (winner != 0 && (!last_winner_valid || winner != last_winner)
                    && winner < int'(key_limit)) begin
                if (token_count < ctcgd_pkg::MAX_STEPS) begin
                    token_sum += winner_prob;
                    token_count++;
                end
                step_results[step_result_count] =
                    token_result(winner, winner_prob, token_count, 1'b0);
                step_result_count++;
            end
            last_winner       = winner;
            last_winner_valid = 1'b1;
            scan_pos          = 0;
            scan_best_prob    = '0;
            scan_best_class   = 0;
        end
        if (qe) begin
            mean = (token_count != 0) ? (token_sum + token_count / 2) / token_count : 0;
            step_results[step_result_count] = mean_result(mean, token_count, 1'b0);
            step_result_count++;
            clear_sequence();
        end
        if (step_result_count > 0)
            step_results[step_result_count - 1].last = 1'b1;
    endfunction

    task automatic check_result();
        t_dec_result want;
        if (pending_results.size() == 0) begin
            flag_mismatch("result_kind of unexpected result", o_result_kind, 'x);
            return;
        end
        want = pending_results.pop_front();
        if (o_result_kind !== want.kind)
            flag_mismatch("result_kind", o_result_kind, want.kind);
        if (o_token_index !== want.index)
            flag_mismatch("token_index", o_token_index, want.index);
        if (o_token_prob !== want.prob)
            flag_mismatch("token_prob", o_token_prob, want.prob);
        if (o_mean_score !== want.mean)
            flag_mismatch("mean_score", o_mean_score, want.mean);
        if (o_token_total !== want.total)
            flag_mismatch("token_total", o_token_total, want.total);
        if (o_run_last !== want.last)
            flag_mismatch("run_last", o_run_last, want.last);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                decode_item(i_class_prob, i_step_end, i_sequence_end);
                if (typed_n == PREDICT) begin
                    for (int k = 0; k < step_result_count; k++)
                        pending_results.insert(pending_results.size(), step_results[k]);
                end else begin
                    for (int k = 0; k < typed_n; k++)
                        pending_results.insert(pending_results.size(), typed_res[k]);
                end
            end
            if (pop && !empty)
                check_result();
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                pop <= ($urandom_range(99, 0) >= recv_stall_pct);
            end
        end
    end

    task automatic send(input logic [ctcgd_pkg::PROB_W-1:0] p, input logic se,
                        input logic qe);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push           <= 1'b1;
        i_class_prob   <= p;
        i_step_end     <= se;
        i_sequence_end <= qe;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_key(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ctcgd_pkg::ADDR_KEY_COUNT;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        key_limit = ctcgd_pkg::KEY_W'(value);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[ctcgd_pkg::KEY_W-1:0] !== key_limit)
            flag_mismatch("key_count readback", prdata[ctcgd_pkg::KEY_W-1:0], key_limit);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic add_row(input int key_before, input int prob, input bit se, input bit qe,
                           input int n_typed, input t_dec_result res0,
                           input t_dec_result res1);
        t_stim_row row;
        row.key_before = key_before;
        row.prob       = ctcgd_pkg::PROB_W'(prob);
        row.se         = se;
        row.qe         = qe;
        row.n_typed    = n_typed;
        row.res0       = res0;
        row.res1       = res1;
        stim_rows.insert(stim_rows.size(), row);
    endtask

    task automatic random_sequence();
        int                           n_steps;
        int                           n_cls;
        int                           plant;
        int                           prev_plant;
        bit                           noisy;
        bit                           qe_only;
        bit                           last_step;
        logic [ctcgd_pkg::PROB_W-1:0] p;
        n_steps    = $urandom_range(8, 1);
        noisy      = ($urandom_range(7, 0) == 0);
        qe_only    = ($urandom_range(5, 0) == 0);
        prev_plant = 0;
        for (int s = 0; s < n_steps; s++) begin
            n_cls = ($urandom_range(15, 0) == 0) ? $urandom_range(40, 9) : $urandom_range(6, 1);
            case ($urandom_range(2, 0))
                0: plant = -1;
                1: begin
                    if (s > 0 && $urandom_range(1, 0) == 1 && prev_plant < n_cls)
                        plant = prev_plant;
                    else
                        plant = $urandom_range(n_cls - 1, 0);
                    prev_plant = plant;
                end
                default: plant = -2;
            endcase
            last_step = (s == n_steps - 1);
            for (int c = 0; c < n_cls; c++) begin
                // tie-heavy, planted winner or free values
                if (plant == -2)
                    p = ctcgd_pkg::PROB_W'($urandom_range(3, 0));
                else if (plant == c)
                    p = ctcgd_pkg::PROB_W'($urandom_range(65535, 60000));
                else if (plant >= 0)
                    p = ctcgd_pkg::PROB_W'($urandom_range(59999, 0));
                else
                    p = ctcgd_pkg::PROB_W'($urandom_range(65535, 0));
                if (c == n_cls - 1)
                    send(p, !(last_step && qe_only), last_step);
                else if (noisy && $urandom_range(9, 0) == 0)
                    send(p, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
                else
                    send(p, 1'b0, 1'b0);
            end
        end
    endtask

    initial begin
        int          key_plan [N_PHASES];
        int          key_val;
        int          start_items;
        t_idle_mode  mode;
        t_dec_result nil;

        nil      = '0;
        key_plan = '{16383, 1, 0, 8191, 3, 8192, RANDOM_KEY, RANDOM_KEY};
        key_limit = ctcgd_pkg::KEY_COUNT_RESET;
        clear_sequence();

        // first step, ties, blank winner, repeats, sequence end without step end
        add_row(NO_CFG, 0,     0, 0, 0, nil, nil);
        add_row(NO_CFG, 65535, 0, 0, 0, nil, nil);
        add_row(NO_CFG, 65535, 1, 0, 1, token_result(1, 65535, 1, 1), nil);
        add_row(NO_CFG, 100,   0, 0, 0, nil, nil);
        add_row(NO_CFG, 100,   1, 0, 0, nil, nil);
        add_row(NO_CFG, 0,     0, 0, 0, nil, nil);
        add_row(NO_CFG, 5,     1, 0, 1, token_result(1, 5, 2, 1), nil);
        add_row(NO_CFG, 0,     0, 0, 0, nil, nil);
        add_row(NO_CFG, 7,     1, 0, 0, nil, nil);
        add_row(NO_CFG, 65535, 0, 1, PREDICT, nil, nil);
        add_row(NO_CFG, 9,     0, 1, 1, mean_result(0, 0, 1), nil);
        add_row(NO_CFG, 1,     0, 0, 0, nil, nil);
        add_row(NO_CFG, 2,     0, 1, 2, token_result(1, 2, 1, 0), mean_result(2, 1, 1));
        // mean of 1 and 2 rounds up
        add_row(NO_CFG, 0,     0, 0, 0, nil, nil);
        add_row(NO_CFG, 1,     1, 0, 1, token_result(1, 1, 1, 1), nil);
        add_row(NO_CFG, 0,     0, 0, 0, nil, nil);
        add_row(NO_CFG, 0,     0, 0, 0, nil, nil);
        add_row(NO_CFG, 2,     1, 1, 2, token_result(2, 2, 2, 0), mean_result(2, 2, 1));
        // key count limits
        add_row(0,      0,     0, 0, 0, nil, nil);
        add_row(NO_CFG, 9,     1, 1, 1, mean_result(0, 0, 1), nil);
        add_row(2,      0,     0, 0, 0, nil, nil);
        add_row(NO_CFG, 0,     0, 0, 0, nil, nil);
        add_row(NO_CFG, 50,    1, 0, 0, nil, nil);
        add_row(NO_CFG, 0,     0, 0, 0, nil, nil);
        add_row(NO_CFG, 50,    0, 1, 2, token_result(1, 50, 1, 0), mean_result(50, 1, 1));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[r]) begin
            if (stim_rows[r].key_before != NO_CFG) begin
                drain();
                program_key(stim_rows[r].key_before);
            end
            typed_n      = stim_rows[r].n_typed;
            typed_res[0] = stim_rows[r].res0;
            typed_res[1] = stim_rows[r].res1;
            send(stim_rows[r].prob, stim_rows[r].se, stim_rows[r].qe);
        end
        typed_n = PREDICT;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            key_val = (key_plan[ph] == RANDOM_KEY) ? $urandom_range(8192, 1) : key_plan[ph];
            program_key(key_val);
            mode = t_idle_mode'(ph % 4);
            case (mode)
                IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                IDLE_SEND: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default:   begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            if (ph == 0)
                hold_req = 1'b1;
            start_items = items_sent;
            while (items_sent - start_items < PHASE_ITEMS)
                random_sequence();
        end

        drain();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
